// ----- sv/ipv6csc_pkg.sv -----
package ipv6csc_pkg;

  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
  localparam logic [5:0]  MIN_PACKET   = 6'd48;
  localparam logic [5:0]  ADDR_START   = 6'd8;
  localparam logic [5:0]  PLEN_HI_POS  = 6'd4;
  localparam logic [5:0]  PLEN_LO_POS  = 6'd5;
  localparam logic [5:0]  NH_POS       = 6'd6;
  localparam logic [5:0]  ICMP_CK_HI   = 6'd42;
  localparam logic [5:0]  ICMP_CK_LO   = 6'd43;
  localparam logic [5:0]  UDP_LEN_HI   = 6'd44;
  localparam logic [5:0]  UDP_LEN_LO   = 6'd45;
  localparam logic [5:0]  UDP_CK_HI    = 6'd46;
  localparam logic [5:0]  UDP_CK_LO    = 6'd47;
  localparam logic [15:0] ALL_ONES     = 16'hffff;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_UNSUP    = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  // Ones'-complement add with end-around carry; one fold covers two 16-bit operands.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- sv/ipv6_transport_checksum_check.sv -----
// IPv6 UDP/ICMPv6 checksum checker and filler. Feed the packet one byte per
// transaction from the first IPv6 header byte, with last_byte_i on the final byte.
// The block takes one byte every cycle while in_stall_o is low; each byte pair costs
// one 16-bit end-around add into the running sum. Only the final byte yields a
// result via final-byte and output registers: fill_value_o is the value to write into
// the transport checksum field (network order) and status_o reports match, mismatch,
// unsupported next header or a packet shorter than 48 bytes (fill value 0 then).
// The output register lets new bytes flow in while a result waits on out_stall_i.
module ipv6_transport_checksum_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] fill_value_o,
  output logic [1:0]  status_o
);
  import ipv6csc_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] data_q;
  logic       last_q;

  // per-packet state
  logic [5:0]  pos_q;
  logic        phase_q;
  logic [7:0]  pend_q;
  logic [7:0]  nh_q;
  logic [15:0] plen_q;
  logic [15:0] sum_q;
  logic [15:0] rx_q;
  logic [15:0] ulen_q;

  // final-byte register
  logic        fin_valid_q;
  logic [15:0] fin_sum_q;
  logic [15:0] fin_lp_q;
  logic [15:0] fin_rx_q;
  logic        fin_udp_q;
  logic        fin_icmp_q;
  logic        fin_trunc_q;

  // output register
  logic        out_valid_q;
  logic [15:0] out_fill_q;
  status_e     out_status_q;

  logic        out_ready;
  logic        fin_go;
  logic        proc;

  logic [7:0]  nh_d;
  logic [15:0] plen_d;
  logic [15:0] ulen_d;
  logic [15:0] rx_d;
  logic [7:0]  pend_d;
  logic [15:0] sum_d;
  logic [5:0]  pos_d;
  logic        is_udp;
  logic        is_icmp;
  logic        is_ck;
  logic [7:0]  eff;
  logic [15:0] addend;
  logic [15:0] lp_d;

  logic [15:0] fin_s;
  logic [15:0] fin_ans;
  logic [15:0] fill_d;
  status_e     status_d;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fin_go     = !fin_valid_q || out_ready;
  assign proc       = in_valid_q && fin_go;
  assign in_stall_o = in_valid_q && !fin_go;

  // byte processing
  always_comb begin
    nh_d   = (pos_q == NH_POS) ? data_q : nh_q;
    plen_d = plen_q;
    if (pos_q == PLEN_HI_POS) plen_d[15:8] = data_q;
    if (pos_q == PLEN_LO_POS) plen_d[7:0]  = data_q;
    is_udp  = (nh_d == PROTO_UDP);
    is_icmp = (nh_d == PROTO_ICMPV6);
    ulen_d = ulen_q;
    if (is_udp && pos_q == UDP_LEN_HI) ulen_d[15:8] = data_q;
    if (is_udp && pos_q == UDP_LEN_LO) ulen_d[7:0]  = data_q;
    is_ck = (is_udp && (pos_q == UDP_CK_HI || pos_q == UDP_CK_LO)) ||
            (is_icmp && (pos_q == ICMP_CK_HI || pos_q == ICMP_CK_LO));
    rx_d = rx_q;
    if (is_ck && !pos_q[0]) rx_d[15:8] = data_q;
    if (is_ck && pos_q[0])  rx_d[7:0]  = data_q;
    eff    = (pos_q < ADDR_START || is_ck) ? 8'd0 : data_q;
    addend = phase_q ? {pend_q, eff} : {eff, 8'd0};
    sum_d  = (phase_q || last_q) ? oc_add(sum_q, addend) : sum_q;
    pend_d = phase_q ? pend_q : eff;
    pos_d  = (pos_q < MIN_PACKET) ? pos_q + 6'd1 : pos_q;
    lp_d   = oc_add(is_udp ? ulen_d : plen_d,
                    {8'd0, is_udp ? PROTO_UDP : PROTO_ICMPV6});
  end

  // result from the captured final sum
  always_comb begin
    fin_s   = oc_add(fin_sum_q, fin_lp_q);
    fin_ans = ~fin_s;
    if (fin_udp_q && fin_ans == 16'd0) fin_ans = ALL_ONES;
    if (fin_trunc_q) begin
      fill_d   = 16'd0;
      status_d = ST_TRUNC;
    end else if (!fin_udp_q && !fin_icmp_q) begin
      fill_d   = 16'd0;
      status_d = ST_UNSUP;
    end else if (fin_icmp_q && fin_ans == 16'd0 && fin_rx_q == ALL_ONES) begin
      fill_d   = 16'd0;
      status_d = ST_MATCH;
    end else begin
      fill_d   = fin_ans;
      status_d = (fin_ans == fin_rx_q) ? ST_MATCH : ST_MISMATCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      phase_q     <= 1'b0;
      pend_q      <= '0;
      nh_q        <= '0;
      plen_q      <= '0;
      sum_q       <= '0;
      rx_q        <= '0;
      ulen_q      <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fin_go) begin
        fin_valid_q <= proc && last_q;
      end
      if (out_ready) begin
        out_valid_q <= fin_valid_q;
      end
      if (proc) begin
        if (last_q) begin
          // clear for the next packet
          pos_q   <= '0;
          phase_q <= 1'b0;
          pend_q  <= '0;
          nh_q    <= '0;
          plen_q  <= '0;
          sum_q   <= '0;
          rx_q    <= '0;
          ulen_q  <= '0;
        end else begin
          pos_q   <= pos_d;
          phase_q <= ~phase_q;
          pend_q  <= pend_d;
          nh_q    <= nh_d;
          plen_q  <= plen_d;
          sum_q   <= sum_d;
          rx_q    <= rx_d;
          ulen_q  <= ulen_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (proc && last_q) begin
      fin_sum_q   <= sum_d;
      fin_lp_q    <= lp_d;
      fin_rx_q    <= rx_d;
      fin_udp_q   <= is_udp;
      fin_icmp_q  <= is_icmp;
      fin_trunc_q <= (pos_q < MIN_PACKET - 6'd1);
    end
    if (fin_valid_q && out_ready) begin
      out_fill_q   <= fill_d;
      out_status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fill_value_o = out_fill_q;
  assign status_o     = out_status_q;

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MIN_PACKET)
    else $error("byte position beyond saturation");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && last_q |=> pos_q == 6'd0 && !phase_q && sum_q == 16'd0)
    else $error("packet state not cleared after final byte");

  a_no_fill_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == ST_TRUNC || out_status_q == ST_UNSUP)
      |-> out_fill_q == 16'd0)
    else $error("nonzero fill value with error status");

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> fin_valid_q == $past(proc && last_q))
    else $error("final-byte register out of step with input");

endmodule
